[hw/rtl/olrs_pkg.sv]
// ----------------------------------------------------------------------------
// Occupancy lighting relay sequencer package
// Shared types, codes and constants of the relay sequencer.
// ----------------------------------------------------------------------------
package olrs_pkg;

    localparam int unsigned MS_PER_S   = 1000;
    localparam int unsigned MS_PER_MIN = 60000;

    localparam int unsigned AUTO_MS_W   = 26;
    localparam int unsigned MIN_MS_W    = 24;
    localparam int unsigned FOLLOW_MS_W = 17;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned CFG_IDX_W   = 3;

    localparam int unsigned RST_AUTO_TIMEOUT_S = 300;
    localparam int unsigned RST_TIMEOUT_MIN    = 30;
    localparam int unsigned RST_FILL_TIME_MS   = 2500;

    typedef enum logic [2:0] {
        CMD_TICK       = 3'd0,
        CMD_RAMP_UP    = 3'd1,
        CMD_RAMP_MOVE  = 3'd2,
        CMD_RADAR      = 3'd3,
        CMD_NIGHT      = 3'd4,
        CMD_TOGGLE     = 3'd5,
        CMD_LONG_PRESS = 3'd6
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AUTO_TIMEOUT   = 3'd0,
        CFG_MANUAL_TIMEOUT = 3'd1,
        CFG_FORGET_TWO     = 3'd2,
        CFG_FORGET_THREE   = 3'd3,
        CFG_FILL_TIME      = 3'd4,
        CFG_FOLLOW_ENABLE  = 3'd5
    } t_cfg_idx;

    localparam logic [1:0] FILL_NONE = 2'd0;
    localparam logic [1:0] FILL_SLOW = 2'd1;
    localparam logic [1:0] FILL_FAST = 2'd2;

    typedef enum logic [1:0] {
        FS_IDLE    = 2'd0,
        FS_WAITING = 2'd1,
        FS_READY   = 2'd2
    } t_follow;

    typedef struct packed {
        logic [2:0]  command;
        logic [31:0] time_ms;
        logic        active;
        logic        motion;
        logic        still_target;
        logic [1:0]  relay_index;
        logic        anim_busy;
    } t_item;

    typedef struct packed {
        logic [3:0] relay_on;
        logic [3:0] relay_auto;
        logic [3:0] relay_disabled;
        logic [1:0] fill_request;
        logic       unfill_request;
        logic       motion_recent;
        logic       night;
        logic       state_notice;
    } t_result;

    typedef struct packed {
        logic [AUTO_MS_W-1:0]   auto_ms;
        logic [MIN_MS_W-1:0]    manual_ms;
        logic [MIN_MS_W-1:0]    forget_two_ms;
        logic [MIN_MS_W-1:0]    forget_three_ms;
        logic [FOLLOW_MS_W-1:0] follow_ms;
        logic                   follow_en;
    } t_cfg;

    typedef struct packed {
        logic [3:0]        on;
        logic [3:0]        dis;
        logic [3:0]        au;
        logic [1:0][31:0]  dl;
        logic [1:0]        dl_vld;
        logic [2:0][31:0]  lm;
        logic [2:0]        lm_vld;
        logic              unfill_pending;
        t_follow           fs;
        logic [31:0]       arm_time;
        logic              motion_flag;
        logic [31:0]       motion_time;
        logic              night;
    } t_state;

    localparam t_state STATE_RESET = '0;

endpackage

[hw/rtl/occupancy_lighting_relay_sequencer_core.sv]
// ----------------------------------------------------------------------------
// Occupancy lighting relay sequencer core
// Event-driven sequencer for four lighting relays with fill/unfill requests.
//
//   Channel  | Handshake                  | Payload
//   ---------+----------------------------+------------------------------------
//   event    | i_in_valid / o_in_stall    | command, time, flags, relay index
//   result   | o_out_valid / i_out_stall  | relay bits, requests, status
//   config   | i_cfg_we                   | i_cfg_index, i_cfg_data
//
// An accepted event sits in the input register while the update logic works
// on it, and its result beat enters the result register once that register is
// free or being taken, so a stalled result holds the event back.
// A new event is accepted every cycle while results are taken.
// Reset is synchronous and returns all relays off, day and default registers.
// A stalled result holds its beat while one more event waits in the input register.
// ----------------------------------------------------------------------------
module occupancy_lighting_relay_sequencer_core import olrs_pkg::*; #(
    parameter int unsigned FOLLOW_DELAY_MS = 500,
    parameter int unsigned MOTION_HOLD_MS  = 5000
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [2:0]            i_command,
    input  logic [31:0]           i_time_ms,
    input  logic                  i_active,
    input  logic                  i_motion,
    input  logic                  i_still_target,
    input  logic [1:0]            i_relay_index,
    input  logic                  i_anim_busy,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [3:0]            o_relay_on,
    output logic [3:0]            o_relay_auto,
    output logic [3:0]            o_relay_disabled,
    output logic [1:0]            o_fill_request,
    output logic                  o_unfill_request,
    output logic                  o_motion_recent,
    output logic                  o_night,
    output logic                  o_state_notice
);

    t_cfg    r_cfg;
    t_state  r_state;
    t_state  n_state;
    t_item   r_item;
    t_result r_result;
    t_result n_result;
    logic    r_in_vld;
    logic    r_out_vld;
    logic    in_acc;
    logic    advance;

    assign advance    = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_in_vld && !advance;
    assign in_acc     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.auto_ms         <= AUTO_MS_W'(RST_AUTO_TIMEOUT_S * MS_PER_S);
            r_cfg.manual_ms       <= MIN_MS_W'(RST_TIMEOUT_MIN * MS_PER_MIN);
            r_cfg.forget_two_ms   <= MIN_MS_W'(RST_TIMEOUT_MIN * MS_PER_MIN);
            r_cfg.forget_three_ms <= MIN_MS_W'(RST_TIMEOUT_MIN * MS_PER_MIN);
            r_cfg.follow_ms       <= FOLLOW_MS_W'(RST_FILL_TIME_MS + FOLLOW_DELAY_MS);
            r_cfg.follow_en       <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_AUTO_TIMEOUT: begin
                    r_cfg.auto_ms <= AUTO_MS_W'(i_cfg_data) * AUTO_MS_W'(MS_PER_S);
                end
                CFG_MANUAL_TIMEOUT: begin
                    r_cfg.manual_ms <= MIN_MS_W'(i_cfg_data[7:0]) * MIN_MS_W'(MS_PER_MIN);
                end
                CFG_FORGET_TWO: begin
                    r_cfg.forget_two_ms <= MIN_MS_W'(i_cfg_data[7:0]) * MIN_MS_W'(MS_PER_MIN);
                end
                CFG_FORGET_THREE: begin
                    r_cfg.forget_three_ms <= MIN_MS_W'(i_cfg_data[7:0])
                                             * MIN_MS_W'(MS_PER_MIN);
                end
                CFG_FILL_TIME: begin
                    r_cfg.follow_ms <= FOLLOW_MS_W'(i_cfg_data)
                                       + FOLLOW_MS_W'(FOLLOW_DELAY_MS);
                end
                CFG_FOLLOW_ENABLE: begin
                    r_cfg.follow_en <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= STATE_RESET;
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_acc) begin
                r_in_vld <= 1'b1;
            end else if (advance) begin
                r_in_vld <= 1'b0;
            end
            if (advance) begin
                r_state   <= n_state;
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_item.command      <= i_command;
            r_item.time_ms      <= i_time_ms;
            r_item.active       <= i_active;
            r_item.motion       <= i_motion;
            r_item.still_target <= i_still_target;
            r_item.relay_index  <= i_relay_index;
            r_item.anim_busy    <= i_anim_busy;
        end
        if (advance) begin
            r_result <= n_result;
        end
    end

    olrs_update #(
        .MOTION_HOLD_MS (MOTION_HOLD_MS)
    ) u_update (
        .i_state  (r_state),
        .i_item   (r_item),
        .i_cfg    (r_cfg),
        .o_state  (n_state),
        .o_result (n_result)
    );

    assign o_out_valid      = r_out_vld;
    assign o_relay_on       = r_result.relay_on;
    assign o_relay_auto     = r_result.relay_auto;
    assign o_relay_disabled = r_result.relay_disabled;
    assign o_fill_request   = r_result.fill_request;
    assign o_unfill_request = r_result.unfill_request;
    assign o_motion_recent  = r_result.motion_recent;
    assign o_night          = r_result.night;
    assign o_state_notice   = r_result.state_notice;

endmodule

[hw/rtl/olrs_update.sv]
// ----------------------------------------------------------------------------
// Relay sequencer event update
// Computes the next sequencer state and the result beat for one event.
// ----------------------------------------------------------------------------
module olrs_update import olrs_pkg::*; #(
    parameter int unsigned MOTION_HOLD_MS = 5000
) (
    input  t_state  i_state,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_state  o_state,
    output t_result o_result
);

    function automatic logic expired(logic [31:0] now, logic [31:0] dl);
        logic [31:0] diff;
        diff = now - dl;
        return !diff[31];
    endfunction

    function automatic t_state relay_drop(t_state s, logic [1:0] i);
        s.on[i] = 1'b0;
        s.au[i] = 1'b0;
        if (i == 2'd0) begin
            s.dl_vld[0] = 1'b0;
        end
        if (i == 2'd1) begin
            s.dl_vld[1] = 1'b0;
        end
        return s;
    endfunction

    function automatic t_state relay_one_off(t_state s);
        if (s.on[0]) begin
            if (s.on[1] && s.au[1]) begin
                s    = relay_drop(s, 2'd1);
                s.fs = FS_IDLE;
            end
            s.unfill_pending = 1'b1;
            s.dl_vld[0]      = 1'b0;
        end
        return s;
    endfunction

    function automatic t_state arm_follow(t_state s, logic [31:0] now, logic en);
        if (!s.dis[1] && en) begin
            s.fs       = FS_WAITING;
            s.arm_time = now;
        end
        return s;
    endfunction

    function automatic t_state touch_all(t_state s, logic [31:0] now);
        s.lm[0]  = now;
        s.lm[1]  = now;
        s.lm[2]  = now;
        s.lm_vld = 3'b111;
        return s;
    endfunction

    function automatic t_state relay_one_auto(t_state s, logic [31:0] now,
                                              logic [31:0] tmo, logic en);
        if (s.on[0]) begin
            s.dl[0]     = now + tmo;
            s.dl_vld[0] = 1'b1;
            s.lm[0]     = now;
            s.lm_vld[0] = 1'b1;
        end else if (!s.dis[0]) begin
            s.au[0]     = 1'b1;
            s.dl[0]     = now + tmo;
            s.dl_vld[0] = 1'b1;
            s.on[0]     = 1'b1;
            s           = arm_follow(s, now, en);
            s           = touch_all(s, now);
        end
        return s;
    endfunction

    t_state      s;
    logic [1:0]  fill;
    logic        unfill;
    logic        notice;
    logic [31:0] now;
    logic [31:0] auto_ms;
    logic [1:0]  idx;

    assign now     = i_item.time_ms;
    assign auto_ms = 32'(i_cfg.auto_ms);
    assign idx     = i_item.relay_index;

    always_comb begin
        s      = i_state;
        fill   = FILL_NONE;
        unfill = 1'b0;
        notice = 1'b0;
        unique case (t_cmd'(i_item.command))
            CMD_TICK: begin
                if (s.on[0] && !s.unfill_pending && s.dl_vld[0] && expired(now, s.dl[0])) begin
                    unfill = 1'b1;
                    s      = relay_one_off(s);
                end
                if (s.unfill_pending && !i_item.anim_busy) begin
                    s.unfill_pending = 1'b0;
                    s                = relay_drop(s, 2'd0);
                    s.fs             = FS_IDLE;
                end
                if (s.fs == FS_WAITING && !i_item.anim_busy
                        && (now - s.arm_time) >= 32'(i_cfg.follow_ms)) begin
                    s.fs = FS_READY;
                end
                if (s.fs == FS_READY) begin
                    s.fs = FS_IDLE;
                    if (!s.dis[1] && !s.on[1]) begin
                        s.au[1]     = 1'b1;
                        s.dl[1]     = now + auto_ms;
                        s.dl_vld[1] = 1'b1;
                        s.on[1]     = 1'b1;
                    end
                end
                if (s.on[1] && s.au[1] && s.dl_vld[1] && expired(now, s.dl[1])) begin
                    s = relay_drop(s, 2'd1);
                end
                if (s.on[1] && !s.au[1] && s.lm_vld[0]
                        && (now - s.lm[0]) >= 32'(i_cfg.forget_two_ms)) begin
                    s = relay_drop(s, 2'd1);
                end
                if (s.on[2] && s.lm_vld[1]
                        && (now - s.lm[1]) >= 32'(i_cfg.forget_three_ms)) begin
                    s = relay_drop(s, 2'd2);
                end
                if (s.on[3] && s.lm_vld[2]
                        && (now - s.lm[2]) >= 32'(i_cfg.forget_three_ms)) begin
                    s = relay_drop(s, 2'd3);
                end
                if (s.motion_flag && (now - s.motion_time) >= 32'(MOTION_HOLD_MS)) begin
                    s.motion_flag = 1'b0;
                end
            end
            CMD_RAMP_UP, CMD_RAMP_MOVE: begin
                if (i_item.active && s.night) begin
                    if (!s.on[0] && !s.dis[0]) begin
                        fill = FILL_SLOW;
                    end
                    s = relay_one_auto(s, now, auto_ms, i_cfg.follow_en);
                end
            end
            CMD_RADAR: begin
                if (i_item.motion || i_item.still_target) begin
                    s.motion_flag = 1'b1;
                    s.motion_time = now;
                    s             = touch_all(s, now);
                    if (s.night) begin
                        if (!s.on[0] && !s.dis[0]) begin
                            fill = FILL_FAST;
                        end
                        s = relay_one_auto(s, now, auto_ms, i_cfg.follow_en);
                    end
                end
            end
            CMD_NIGHT: begin
                if (i_item.active != s.night) begin
                    s.night = i_item.active;
                    if (!i_item.active && s.on[0] && s.au[0]) begin
                        unfill = 1'b1;
                        s      = relay_one_off(s);
                    end
                end
            end
            CMD_TOGGLE: begin
                if (!s.dis[idx]) begin
                    if (s.on[idx]) begin
                        if (idx == 2'd0) begin
                            unfill = 1'b1;
                            s      = relay_one_off(s);
                        end else begin
                            s = relay_drop(s, idx);
                        end
                    end else begin
                        s.au[idx] = 1'b0;
                        s.on[idx] = 1'b1;
                        case (idx)
                            2'd0: begin
                                s.dl[0]     = now + 32'(i_cfg.manual_ms);
                                s.dl_vld[0] = 1'b1;
                                fill        = FILL_SLOW;
                                s           = arm_follow(s, now, i_cfg.follow_en);
                            end
                            2'd1: begin
                                s.dl[1]     = now + 32'(i_cfg.forget_two_ms);
                                s.dl_vld[1] = 1'b1;
                                s.lm[0]     = now;
                                s.lm_vld[0] = 1'b1;
                            end
                            2'd2: begin
                                s.lm[1]     = now;
                                s.lm_vld[1] = 1'b1;
                            end
                            default: begin
                                s.lm[2]     = now;
                                s.lm_vld[2] = 1'b1;
                            end
                        endcase
                    end
                end
            end
            CMD_LONG_PRESS: begin
                if (s.dis[idx]) begin
                    s.dis[idx] = 1'b0;
                end else begin
                    if (s.on[idx]) begin
                        if (idx == 2'd0) begin
                            unfill = 1'b1;
                            s      = relay_one_off(s);
                        end else begin
                            s = relay_drop(s, idx);
                        end
                    end
                    s.dis[idx] = 1'b1;
                end
                notice = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign o_state                 = s;
    assign o_result.relay_on       = s.on;
    assign o_result.relay_auto     = s.au;
    assign o_result.relay_disabled = s.dis;
    assign o_result.fill_request   = fill;
    assign o_result.unfill_request = unfill;
    assign o_result.motion_recent  = s.motion_flag;
    assign o_result.night          = s.night;
    assign o_result.state_notice   = notice;

endmodule

[hw/rtl/olrs_checker.sv]
// ----------------------------------------------------------------------------
// Relay sequencer port checker
// Checks result beats seen on the ports of the sequencer core.
// ----------------------------------------------------------------------------
module olrs_checker import olrs_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [3:0] o_relay_on,
    input logic [3:0] o_relay_auto,
    input logic [3:0] o_relay_disabled,
    input logic [1:0] o_fill_request,
    input logic       o_unfill_request,
    input logic       o_motion_recent,
    input logic       o_night,
    input logic       o_state_notice
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_relay_on)
            && $stable(o_relay_auto) && $stable(o_relay_disabled)
            && $stable(o_fill_request) && $stable(o_unfill_request)
            && $stable(o_motion_recent) && $stable(o_night) && $stable(o_state_notice))
        else $error("result beat changed while stalled");

    a_fill_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_fill_request != FILL_NONE |-> o_relay_on[0])
        else $error("fill requested without relay one on");

    a_unfill_auto: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_unfill_request |-> !o_relay_auto[1])
        else $error("unfill requested while relay two still automatic");

    a_auto_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_relay_auto & ~o_relay_on) == 4'b0000)
        else $error("automatic mark on a relay that is off");

    a_dis_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_relay_disabled[3:1] & o_relay_on[3:1]) == 3'b000)
        else $error("disabled relay two to four is on");

endmodule

bind occupancy_lighting_relay_sequencer_core olrs_checker u_olrs_checker (.*);

[verif/occupancy_lighting_relay_sequencer_core_test.sv]
// ----------------------------------------------------------------------------
// Occupancy lighting relay sequencer core testbench
// Drives event beats with random gaps and result stalls, predicts each result
// with a behavioral copy of the relay sequencer and compares every field.
// ----------------------------------------------------------------------------
module occupancy_lighting_relay_sequencer_core_test;
    import olrs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned FOLLOW_DELAY_MS = 500;
    localparam int unsigned MOTION_HOLD_MS  = 5000;
    localparam logic [2:0]  CMD_UNKNOWN     = 3'd7;
    localparam int unsigned LONG_HOLD       = 300;
    localparam int unsigned CYCLE_LIMIT     = 500000;

    logic                  i_clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    t_cfg_idx              cfg_index = CFG_AUTO_TIMEOUT;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  out_stall = 1'b0;
    t_item                 ev_drv = '0;

    logic                  o_in_stall;
    logic                  o_out_valid;
    t_result               res_dut;

    always #5 i_clk = ~i_clk;

    occupancy_lighting_relay_sequencer_core #(
        .FOLLOW_DELAY_MS (FOLLOW_DELAY_MS),
        .MOTION_HOLD_MS  (MOTION_HOLD_MS)
    ) u_top (
        .i_clk            (i_clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .o_in_stall       (o_in_stall),
        .i_command        (ev_drv.command),
        .i_time_ms        (ev_drv.time_ms),
        .i_active         (ev_drv.active),
        .i_motion         (ev_drv.motion),
        .i_still_target   (ev_drv.still_target),
        .i_relay_index    (ev_drv.relay_index),
        .i_anim_busy      (ev_drv.anim_busy),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (out_stall),
        .o_relay_on       (res_dut.relay_on),
        .o_relay_auto     (res_dut.relay_auto),
        .o_relay_disabled (res_dut.relay_disabled),
        .o_fill_request   (res_dut.fill_request),
        .o_unfill_request (res_dut.unfill_request),
        .o_motion_recent  (res_dut.motion_recent),
        .o_night          (res_dut.night),
        .o_state_notice   (res_dut.state_notice)
    );

    // Sequencer copy: timing registers and relay state.
    logic [15:0] auto_timeout_s     = 16'(RST_AUTO_TIMEOUT_S);
    logic [7:0]  manual_timeout_min = 8'(RST_TIMEOUT_MIN);
    logic [7:0]  forget_two_min     = 8'(RST_TIMEOUT_MIN);
    logic [7:0]  forget_three_min   = 8'(RST_TIMEOUT_MIN);
    logic [15:0] fill_time_ms       = 16'(RST_FILL_TIME_MS);
    logic        follow_enable      = 1'b1;

    logic [3:0]  relay_lit = '0;
    logic [3:0]  relay_auto = '0;
    logic [3:0]  relay_blocked = '0;
    logic [31:0] due_ms [4] = '{default: '0};
    logic [3:0]  due_live = '0;
    logic [31:0] motion_ref_ms [3] = '{default: '0};
    logic [2:0]  motion_ref_live = '0;
    logic        unfill_wait = 1'b0;
    t_follow     follow_st = FS_IDLE;
    logic [31:0] arm_ms = '0;
    logic        motion_seen = 1'b0;
    logic [31:0] motion_ms = '0;
    logic        dark_now = 1'b0;
    logic [1:0]  fill_req;
    logic        unfill_req;

    t_item       pending_events [$];
    t_result     expected_results [$];
    logic [31:0] sim_ms = '0;
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;
    bit          beat_taken = 1'b0;
    bit          calm = 1'b0;
    bit          long_hold_req = 1'b0;
    int unsigned long_hold_left = 0;
    int unsigned tx_gap = 0, tx_quiet = 0, rx_gap = 0, rx_quiet = 0;

    function automatic logic [31:0] since(logic [31:0] now, logic [31:0] start);
        return now - start;
    endfunction

    function automatic bit is_due(logic [31:0] now, logic [31:0] deadline);
        return since(now, deadline) < 32'h8000_0000;
    endfunction

    task automatic drop_relay(int unsigned i);
        relay_lit[i] = 1'b0;
        relay_auto[i] = 1'b0;
        due_live[i] = 1'b0;
        due_ms[i] = '0;
    endtask

    task automatic set_due(int unsigned i, logic [31:0] when);
        due_ms[i] = when;
        due_live[i] = 1'b1;
    endtask

    task automatic touch_ref(int unsigned k, logic [31:0] now);
        motion_ref_ms[k] = now;
        motion_ref_live[k] = 1'b1;
    endtask

    task automatic arm_follow(logic [31:0] now);
        if (!relay_blocked[1] && follow_enable) begin
            follow_st = FS_WAITING;
            arm_ms = now;
        end
    endtask

    task automatic relay_one_auto(logic [1:0] kind, logic [31:0] now);
        logic [31:0] hold_ms;
        hold_ms = auto_timeout_s * MS_PER_S;
        if (relay_lit[0]) begin
            set_due(0, now + hold_ms);
            touch_ref(0, now);
            return;
        end
        if (relay_blocked[0]) return;
        relay_auto[0] = 1'b1;
        set_due(0, now + hold_ms);
        relay_lit[0] = 1'b1;
        fill_req = kind;
        arm_follow(now);
        for (int k = 0; k < 3; k++) touch_ref(k, now);
    endtask

    task automatic relay_one_off();
        if (!relay_lit[0]) return;
        if (relay_lit[1] && relay_auto[1]) begin
            drop_relay(1);
            follow_st = FS_IDLE;
        end
        unfill_req = 1'b1;
        unfill_wait = 1'b1;
        due_live[0] = 1'b0;
        due_ms[0] = '0;
    endtask

    task automatic switch_off(int unsigned i);
        if (i == 0) relay_one_off();
        else drop_relay(i);
    endtask

    task automatic forget_check(int unsigned i, logic [31:0] now, logic [31:0] limit);
        if (motion_ref_live[i-1] && since(now, motion_ref_ms[i-1]) >= limit) drop_relay(i);
    endtask

    task automatic predict_result(input t_item ev, output t_result res);
        logic [31:0] now;
        int unsigned idx;
        logic        notice;
        now = ev.time_ms;
        idx = ev.relay_index;
        notice = 1'b0;
        fill_req = FILL_NONE;
        unfill_req = 1'b0;
        case (ev.command)
            CMD_TICK: begin
                if (relay_lit[0] && !unfill_wait && due_live[0] && is_due(now, due_ms[0]))
                    relay_one_off();
                if (unfill_wait && !ev.anim_busy) begin
                    unfill_wait = 1'b0;
                    drop_relay(0);
                    follow_st = FS_IDLE;
                end
                if (follow_st == FS_WAITING && !ev.anim_busy &&
                    since(now, arm_ms) >= fill_time_ms + FOLLOW_DELAY_MS)
                    follow_st = FS_READY;
                if (follow_st == FS_READY) begin
                    follow_st = FS_IDLE;
                    if (!relay_blocked[1] && !relay_lit[1]) begin
                        relay_auto[1] = 1'b1;
                        set_due(1, now + auto_timeout_s * MS_PER_S);
                        relay_lit[1] = 1'b1;
                    end
                end
                if (relay_lit[1] && relay_auto[1] && due_live[1] && is_due(now, due_ms[1]))
                    drop_relay(1);
                if (relay_lit[1] && !relay_auto[1])
                    forget_check(1, now, forget_two_min * MS_PER_MIN);
                if (relay_lit[2]) forget_check(2, now, forget_three_min * MS_PER_MIN);
                if (relay_lit[3]) forget_check(3, now, forget_three_min * MS_PER_MIN);
                if (motion_seen && since(now, motion_ms) >= MOTION_HOLD_MS)
                    motion_seen = 1'b0;
            end
            CMD_RAMP_UP, CMD_RAMP_MOVE: begin
                if (ev.active && dark_now) relay_one_auto(FILL_SLOW, now);
            end
            CMD_RADAR: begin
                if (ev.motion || ev.still_target) begin
                    motion_seen = 1'b1;
                    motion_ms = now;
                    for (int k = 0; k < 3; k++) touch_ref(k, now);
                    if (dark_now) relay_one_auto(FILL_FAST, now);
                end
            end
            CMD_NIGHT: begin
                if (ev.active != dark_now) begin
                    dark_now = ev.active;
                    if (!dark_now && relay_lit[0] && relay_auto[0]) relay_one_off();
                end
            end
            CMD_TOGGLE: begin
                if (!relay_blocked[idx]) begin
                    if (relay_lit[idx]) begin
                        switch_off(idx);
                    end else begin
                        relay_auto[idx] = 1'b0;
                        relay_lit[idx] = 1'b1;
                        if (idx == 0) begin
                            set_due(0, now + manual_timeout_min * MS_PER_MIN);
                            fill_req = FILL_SLOW;
                            arm_follow(now);
                        end else begin
                            set_due(idx, now + ((idx == 1) ? forget_two_min : forget_three_min)
                                               * MS_PER_MIN);
                            touch_ref(idx - 1, now);
                        end
                    end
                end
            end
            CMD_LONG_PRESS: begin
                if (relay_blocked[idx]) begin
                    relay_blocked[idx] = 1'b0;
                end else begin
                    if (relay_lit[idx]) switch_off(idx);
                    relay_blocked[idx] = 1'b1;
                end
                notice = 1'b1;
            end
            default: ;
        endcase
        res.relay_on = relay_lit;
        res.relay_auto = relay_auto;
        res.relay_disabled = relay_blocked;
        res.fill_request = fill_req;
        res.unfill_request = unfill_req;
        res.motion_recent = motion_seen;
        res.night = dark_now;
        res.state_notice = notice;
    endtask

    task automatic compare_field(string name, logic [3:0] want, logic [3:0] got);
        if (want !== got) begin
            $display("%0t ns: %s expected %0h actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Result side: prediction on each accepted event beat, check on each result beat.
    always @(posedge i_clk) begin
        t_result want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
        beat_taken = rst_n && in_valid && !o_in_stall;
        if (beat_taken) begin
            predict_result(ev_drv, want);
            expected_results.push_back(want);
        end
        if (rst_n && o_out_valid && !out_stall) begin
            if (expected_results.size() == 0) begin
                $display("%0t ns: result beat with nothing expected, actual %h", $time, res_dut);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                compare_field("relay_on", want.relay_on, res_dut.relay_on);
                compare_field("relay_auto", want.relay_auto, res_dut.relay_auto);
                compare_field("relay_disabled", want.relay_disabled, res_dut.relay_disabled);
                compare_field("fill_request", want.fill_request, res_dut.fill_request);
                compare_field("unfill_request", want.unfill_request, res_dut.unfill_request);
                compare_field("motion_recent", want.motion_recent, res_dut.motion_recent);
                compare_field("night", want.night, res_dut.night);
                compare_field("state_notice", want.state_notice, res_dut.state_notice);
            end
        end
    end

    // Event driver.
    always @(negedge i_clk) begin
        if (tx_quiet > 0) tx_quiet--;
        if (rst_n && !(in_valid && !beat_taken)) begin
            if (tx_gap > 0) begin
                tx_gap--;
                in_valid <= 1'b0;
            end else if (pending_events.size() == 0) begin
                in_valid <= 1'b0;
            end else if (!calm && tx_quiet == 0 && $urandom_range(0, 7) == 0) begin
                tx_gap = $urandom_range(1, 17) - 1;
                if ($urandom_range(0, 2) == 0) tx_quiet = tx_gap + $urandom_range(20, 90);
                in_valid <= 1'b0;
            end else begin
                ev_drv <= pending_events.pop_front();
                in_valid <= 1'b1;
            end
        end
    end

    // Result receiver.
    always @(negedge i_clk) begin
        if (rx_quiet > 0) rx_quiet--;
        if (long_hold_left > 0) begin
            long_hold_left--;
            out_stall <= 1'b1;
        end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            long_hold_left = LONG_HOLD - 1;
            out_stall <= 1'b1;
        end else if (rx_gap > 0) begin
            rx_gap--;
            out_stall <= 1'b1;
        end else if (!calm && rx_quiet == 0 && $urandom_range(0, 7) == 0) begin
            rx_gap = $urandom_range(1, 17) - 1;
            if ($urandom_range(0, 2) == 0) rx_quiet = rx_gap + $urandom_range(20, 90);
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    task automatic add_event(logic [2:0] cmd, logic [31:0] at_ms, logic act, logic mov,
                             logic still, logic [1:0] idx, logic busy);
        t_item ev;
        ev.command = cmd;
        ev.time_ms = at_ms;
        ev.active = act;
        ev.motion = mov;
        ev.still_target = still;
        ev.relay_index = idx;
        ev.anim_busy = busy;
        pending_events.push_back(ev);
    endtask

    task automatic add_random_event();
        int unsigned r;
        logic [2:0]  cmd;
        logic        act;
        r = $urandom_range(0, 99);
        if (r < 55) sim_ms += $urandom_range(0, 1500);
        else if (r < 82) sim_ms += $urandom_range(0, 12000);
        else if (r < 94) sim_ms += $urandom_range(0, 150000);
        else if (r < 98) sim_ms += $urandom_range(0, 2000000);
        else sim_ms = $urandom();
        r = $urandom_range(0, 99);
        if (r < 38) cmd = CMD_TICK;
        else if (r < 48) cmd = CMD_RAMP_UP;
        else if (r < 55) cmd = CMD_RAMP_MOVE;
        else if (r < 71) cmd = CMD_RADAR;
        else if (r < 78) cmd = CMD_NIGHT;
        else if (r < 91) cmd = CMD_TOGGLE;
        else if (r < 97) cmd = CMD_LONG_PRESS;
        else cmd = CMD_UNKNOWN;
        act = (cmd == CMD_NIGHT) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 4) != 0);
        add_event(cmd, sim_ms, act, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  2'($urandom_range(0, 3)), $urandom_range(0, 99) < 35);
    endtask

    task automatic wait_drained();
        while (pending_events.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            CFG_AUTO_TIMEOUT:   auto_timeout_s = val;
            CFG_MANUAL_TIMEOUT: manual_timeout_min = val[7:0];
            CFG_FORGET_TWO:     forget_two_min = val[7:0];
            CFG_FORGET_THREE:   forget_three_min = val[7:0];
            CFG_FILL_TIME:      fill_time_ms = val;
            CFG_FOLLOW_ENABLE:  follow_enable = val[0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_timing(logic [15:0] auto_s, logic [15:0] manual_min,
                              logic [15:0] two_min, logic [15:0] three_min,
                              logic [15:0] fill_ms, logic [15:0] follow);
        write_reg(CFG_AUTO_TIMEOUT, auto_s);
        write_reg(CFG_MANUAL_TIMEOUT, manual_min);
        write_reg(CFG_FORGET_TWO, two_min);
        write_reg(CFG_FORGET_THREE, three_min);
        write_reg(CFG_FILL_TIME, fill_ms);
        write_reg(CFG_FOLLOW_ENABLE, follow);
    endtask

    task automatic run_phase(int unsigned count);
        @(posedge i_clk);
        repeat (count) add_random_event();
        wait_drained();
    endtask

    initial begin
        repeat (2) @(negedge i_clk);
        rst_n <= 1'b1;

        // Directed part with the reset timing values.
        add_event(CMD_UNKNOWN, 32'hFFFF_FFFF, 1, 1, 1, 3, 1);
        add_event(CMD_RAMP_UP, 0, 1, 0, 0, 0, 0);
        add_event(CMD_NIGHT, 10, 1, 0, 0, 0, 0);
        add_event(CMD_NIGHT, 20, 1, 0, 0, 0, 0);
        add_event(CMD_RADAR, 30, 0, 0, 0, 0, 0);
        add_event(CMD_RAMP_UP, 100, 1, 0, 0, 0, 1);
        add_event(CMD_RADAR, 200, 0, 1, 0, 0, 0);
        add_event(CMD_TICK, 1000, 0, 0, 0, 0, 1);
        add_event(CMD_TICK, 3300, 0, 0, 0, 0, 0);
        add_event(CMD_RAMP_MOVE, 4000, 0, 0, 0, 0, 0);
        add_event(CMD_TICK, 300300, 0, 0, 0, 0, 1);
        add_event(CMD_NIGHT, 300400, 0, 0, 0, 0, 1);
        add_event(CMD_TICK, 300500, 0, 0, 0, 0, 0);
        add_event(CMD_TOGGLE, 301000, 0, 0, 0, 0, 0);
        add_event(CMD_TOGGLE, 301100, 0, 0, 0, 2, 0);
        add_event(CMD_TOGGLE, 301200, 0, 0, 0, 3, 0);
        add_event(CMD_LONG_PRESS, 301300, 0, 0, 0, 1, 0);
        add_event(CMD_TOGGLE, 301400, 0, 0, 0, 1, 0);
        add_event(CMD_TICK, 305000, 0, 0, 0, 0, 0);
        add_event(CMD_LONG_PRESS, 305100, 0, 0, 0, 1, 0);
        add_event(CMD_LONG_PRESS, 305200, 0, 0, 0, 2, 0);
        add_event(CMD_RADAR, 305300, 0, 0, 1, 0, 0);
        add_event(CMD_TICK, 32'hFFFF_FFF0, 0, 0, 0, 0, 0);
        add_event(CMD_LONG_PRESS, 32'hFFFF_FFF8, 0, 0, 0, 2, 0);
        add_event(CMD_TOGGLE, 5, 0, 0, 0, 0, 0);
        wait_drained();

        set_timing(5, 1, 1, 1, 1000, 1);
        sim_ms = '0;
        run_phase(300);

        set_timing(0, 0, 0, 0, 0, 0);
        run_phase(200);

        set_timing(16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 1);
        sim_ms = 32'hFFF0_0000;
        run_phase(200);

        set_timing(16'($urandom_range(0, 20)), 16'($urandom_range(0, 3)),
                   16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)),
                   16'($urandom_range(0, 6000)), 16'($urandom_range(0, 1)));
        @(posedge i_clk);
        long_hold_req = 1'b1;
        run_phase(400);

        set_timing(16'($urandom_range(1, 40)), 2, 1, 2, 16'($urandom_range(0, 3000)), 1);
        @(posedge i_clk);
        calm = 1'b1;
        run_phase(500);

        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/olrs_pkg.sv
hw/rtl/olrs_update.sv
hw/rtl/occupancy_lighting_relay_sequencer_core.sv
hw/rtl/olrs_checker.sv
verif/occupancy_lighting_relay_sequencer_core_test.sv
